FILE: rtl/core/hlv_pkg.sv
// Shared constants, types and trigonometry helpers for the Hough line vote accumulator.
package hlv_pkg;

	// Accumulator geometry.
	localparam int ANGLE_BINS = 360;
	localparam int RHO_BINS   = 1024;
	localparam int COORD_BITS = 8;
	localparam int CELL_COUNT = ANGLE_BINS * RHO_BINS;

	// Fixed field widths of the channels and the offset register.
	localparam int MODE_W        = 2;
	localparam int PIXEL_W       = 8;
	localparam int EDGE_W        = 8;
	localparam int ANGLE_IDX_W   = 9;
	localparam int RHO_IDX_W     = 10;
	localparam int COUNT_W       = 16;
	localparam int OFFSET_W      = 10;
	localparam logic [OFFSET_W-1:0] RHO_OFFSET_RESET = OFFSET_W'(363);
	localparam logic [COUNT_W-1:0]  COUNT_MAX        = '1;

	// Derived widths.
	localparam int ANGLE_W = $clog2(ANGLE_BINS);
	localparam int RHO_W   = $clog2(RHO_BINS);
	localparam int ADDR_W  = $clog2(CELL_COUNT);

	// Angle arithmetic in whole degrees.
	localparam int FULL_TURN    = 360;
	localparam int HALF_TURN    = 180;
	localparam int QUARTER_TURN = 90;
	localparam int TURN_W       = $clog2(FULL_TURN + 1);
	localparam int QIDX_W       = $clog2(QUARTER_TURN + 1);

	// Fixed-point trig and vote arithmetic.
	localparam int FRAC_BITS   = 14;
	localparam int TRIG_W      = FRAC_BITS + 2;
	localparam int PROD_W      = COORD_BITS + 1 + TRIG_W;
	localparam int SUM_W       = PROD_W + 1;
	localparam int RHO_TRUNC_W = SUM_W - FRAC_BITS;
	localparam int BIN_W       = ((RHO_TRUNC_W > OFFSET_W) ? RHO_TRUNC_W : OFFSET_W) + 1;

	// Command queue depth between front and back.
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// Request mode codes on the input channel.
	localparam logic [MODE_W-1:0] MODE_VOTE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// Sine of 0 to 90 degrees in Q1.14, rounded to nearest.
	localparam logic [FRAC_BITS:0] QUARTER_SINE [0:QUARTER_TURN] = '{
		15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
		15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
		15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
		15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
		15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
		15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
		15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
		15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
		15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
		15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
		15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
		15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
		15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
	};

	// Operations the back end carries out.
	typedef enum logic [1:0] {
		OP_VOTE,
		OP_READ,
		OP_CLEAR
	} cmd_op_t;

	// One queued command.
	typedef struct packed {
		cmd_op_t               op;
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
		logic [ADDR_W-1:0]     read_addr;
		logic                  read_hit;
	} cmd_t;

	// Back-end status seen by the front end.
	typedef struct packed {
		logic init_busy;
	} back_status_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_VOTE,
		BK_DRAIN,
		BK_READ,
		BK_READ_WAIT,
		BK_CLEAR
	} back_state_t;

	// Q1.14 sine of a whole-degree angle below one full turn.
	function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [TURN_W-1:0] d);
		logic [QIDX_W-1:0] idx;
		logic              neg;
		if (d <= TURN_W'(QUARTER_TURN)) begin
			idx = QIDX_W'(d);
			neg = 1'b0;
		end else if (d <= TURN_W'(HALF_TURN)) begin
			idx = QIDX_W'(TURN_W'(HALF_TURN) - d);
			neg = 1'b0;
		end else if (d <= TURN_W'(HALF_TURN + QUARTER_TURN)) begin
			idx = QIDX_W'(d - TURN_W'(HALF_TURN));
			neg = 1'b1;
		end else begin
			idx = QIDX_W'(TURN_W'(FULL_TURN) - d);
			neg = 1'b1;
		end
		return neg ? -TRIG_W'(QUARTER_SINE[idx]) : TRIG_W'(QUARTER_SINE[idx]);
	endfunction

	// Q1.14 cosine, taken as the sine a quarter turn further on.
	function automatic logic signed [TRIG_W-1:0] cosine_q14(input logic [TURN_W-1:0] d);
		logic [TURN_W:0] shifted;
		logic [TURN_W:0] wrapped;
		shifted = (TURN_W + 1)'(d) + (TURN_W + 1)'(QUARTER_TURN);
		wrapped = (shifted >= (TURN_W + 1)'(FULL_TURN)) ?
			shifted - (TURN_W + 1)'(FULL_TURN) : shifted;
		return sine_q14(wrapped[TURN_W-1:0]);
	endfunction

	// Linear store address of the cell at (angle, rho bin).
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ANGLE_W-1:0] angle,
			input logic [RHO_W-1:0] bin);
		return ADDR_W'(angle) * ADDR_W'(RHO_BINS) + ADDR_W'(bin);
	endfunction

endpackage

FILE: rtl/core/hlv_stream_if.sv
// Valid/ready channel interfaces for requests and read results.
interface hlv_cmd_if import hlv_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [MODE_W-1:0]      mode;
	logic [PIXEL_W-1:0]     pixel_row;
	logic [PIXEL_W-1:0]     pixel_col;
	logic [EDGE_W-1:0]      edge_value;
	logic [ANGLE_IDX_W-1:0] angle_index;
	logic [RHO_IDX_W-1:0]   rho_index;

	modport source (
		output valid, mode, pixel_row, pixel_col, edge_value, angle_index, rho_index,
		input  ready
	);
	modport sink (
		input  valid, mode, pixel_row, pixel_col, edge_value, angle_index, rho_index,
		output ready
	);
endinterface

interface hlv_result_if import hlv_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] vote_count;

	modport source (output valid, vote_count, input ready);
	modport sink (input valid, vote_count, output ready);
endinterface

FILE: rtl/core/hough_line_vote_accumulator_core.sv
// Line Hough vote accumulator: a vote request does one read-modify-write per angle bin
// through the single write port of the vote store.
// A cell read leaves the command queue, passes through BK_READ and BK_READ_WAIT and then
// returns its result; it waits in BK_READ while an earlier result still waits for the receiver.
// A clear request sweeps the store one cell per cycle, over all ANGLE_BINS * RHO_BINS cells.
// After reset the same clearing pass runs with request ready held low;
// the offset register resets to 363 and the command queue resets empty.
module hough_line_vote_accumulator_core import hlv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [OFFSET_W-1:0] cfg_wr_data,
	hlv_cmd_if.sink             cmd,
	hlv_result_if.source        result
);

	logic         q_push;
	cmd_t         q_push_cmd;
	logic         q_full;
	logic         q_pop;
	logic         q_valid;
	cmd_t         q_head;
	back_status_t status;

	hlv_front u_front (
		.cmd    (cmd),
		.status (status),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_push_cmd)
	);

	hlv_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head_cmd (q_head)
	);

	hlv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_valid     (q_valid),
		.q_cmd       (q_head),
		.q_pop       (q_pop),
		.status      (status),
		.result      (result)
	);

endmodule

FILE: rtl/core/hlv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hlv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write first port, registered read on the second.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/core/hlv_front.sv
// Front end: accepts request transactions and classifies them into queue commands.
module hlv_front import hlv_pkg::*; (
	hlv_cmd_if.sink      cmd,
	input  back_status_t status,
	input  logic         q_full,
	output logic         q_push,
	output cmd_t         q_cmd
);

	logic useful;

	// Accept whenever the queue has room, except during the clearing pass after reset.
	assign cmd.ready = !q_full && !status.init_busy;

	// Decode the mode; a silent pixel and the unused mode are dropped here.
	always_comb begin
		q_cmd.op        = OP_VOTE;
		q_cmd.row       = COORD_BITS'(cmd.pixel_row);
		q_cmd.col       = COORD_BITS'(cmd.pixel_col);
		q_cmd.read_addr = cell_addr(ANGLE_W'(cmd.angle_index), RHO_W'(cmd.rho_index));
		q_cmd.read_hit  = (int'(cmd.angle_index) < ANGLE_BINS) &&
			(int'(cmd.rho_index) < RHO_BINS);
		useful          = 1'b0;
		case (cmd.mode)
			MODE_VOTE: begin
				q_cmd.op = OP_VOTE;
				useful   = (cmd.edge_value != '0);
			end
			MODE_READ: begin
				q_cmd.op = OP_READ;
				useful   = 1'b1;
			end
			MODE_CLEAR: begin
				q_cmd.op = OP_CLEAR;
				useful   = 1'b1;
			end
			default: begin
				useful = 1'b0;
			end
		endcase
	end

	assign q_push = cmd.valid && cmd.ready && useful;

endmodule

FILE: rtl/core/hlv_cmd_fifo.sv
// Short command queue that decouples the front end from the back end.
module hlv_cmd_fifo import hlv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t head_cmd
);

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full     = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign valid    = (count_q != '0);
	assign head_cmd = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// A push into a full queue would lose a command.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("command pushed into a full queue");

endmodule

FILE: rtl/core/hlv_back.sv
// Back end: votes over all angles, reads single cells and sweeps the store clear.
module hlv_back import hlv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [OFFSET_W-1:0] cfg_wr_data,
	input  logic                q_valid,
	input  cmd_t                q_cmd,
	output logic                q_pop,
	output back_status_t        status,
	hlv_result_if.source        result
);

	back_state_t state_q;
	back_state_t state_d;

	logic [OFFSET_W-1:0]   rho_offset_q;
	logic [ANGLE_W-1:0]    ang_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [COORD_BITS-1:0] row_q;
	logic [COORD_BITS-1:0] col_q;
	logic [ADDR_W-1:0]     rd_addr_q;
	logic                  rd_hit_q;
	logic                  res_valid_q;
	logic [COUNT_W-1:0]    res_count_q;

	logic ang_run;
	logic read_go;
	logic sweep;
	logic clr_last;

	// Vote pipeline registers.
	logic                          valid_s1;
	logic [ANGLE_W-1:0]            angle_s1;
	logic signed [PROD_W-1:0]      prod_row_s1;
	logic signed [PROD_W-1:0]      prod_col_s1;
	logic                          valid_s2;
	logic [ANGLE_W-1:0]            angle_s2;
	logic signed [RHO_TRUNC_W-1:0] rho_s2;
	logic                          valid_s3;
	logic                          hit_s3;
	logic [ADDR_W-1:0]             addr_s3;
	logic                          valid_s4;
	logic [ADDR_W-1:0]             addr_s4;

	logic signed [TRIG_W-1:0]      sin_c;
	logic signed [TRIG_W-1:0]      cos_c;
	logic signed [PROD_W-1:0]      prod_row_c;
	logic signed [PROD_W-1:0]      prod_col_c;
	logic signed [SUM_W-1:0]       sum_c;
	logic signed [SUM_W-1:0]       biased_c;
	logic signed [RHO_TRUNC_W-1:0] rho_c;
	logic signed [BIN_W-1:0]       bin_c;
	logic                          hit_c;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [COUNT_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [COUNT_W-1:0]  ram_rdata;

	assign clr_last = (clr_q == ADDR_W'(CELL_COUNT - 1));

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		ang_run = 1'b0;
		read_go = 1'b0;
		sweep   = 1'b0;
		case (state_q)
			BK_INIT, BK_CLEAR: begin
				sweep = 1'b1;
				if (clr_last) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_cmd.op)
						OP_VOTE:  state_d = BK_VOTE;
						OP_READ:  state_d = BK_READ;
						OP_CLEAR: state_d = BK_CLEAR;
						default:  state_d = BK_IDLE;
					endcase
				end
			end
			BK_VOTE: begin
				ang_run = 1'b1;
				if (ang_q == ANGLE_W'(ANGLE_BINS - 1)) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (!(valid_s1 || valid_s2 || valid_s3 || valid_s4)) begin
					state_d = BK_IDLE;
				end
			end
			BK_READ: begin
				if (!res_valid_q) begin
					read_go = 1'b1;
					state_d = BK_READ_WAIT;
				end
			end
			BK_READ_WAIT: begin
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Sequencer state and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_INIT;
			clr_q        <= '0;
			ang_q        <= '0;
			rho_offset_q <= RHO_OFFSET_RESET;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				rho_offset_q <= cfg_wr_data;
			end
			if (sweep) begin
				clr_q <= clr_last ? '0 : clr_q + 1'b1;
			end
			if (q_pop) begin
				ang_q <= '0;
			end else if (ang_run) begin
				ang_q <= ang_q + 1'b1;
			end
			if (state_q == BK_READ_WAIT) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Command payload and read result.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			row_q     <= q_cmd.row;
			col_q     <= q_cmd.col;
			rd_addr_q <= q_cmd.read_addr;
			rd_hit_q  <= q_cmd.read_hit;
		end
		if (state_q == BK_READ_WAIT) begin
			res_count_q <= rd_hit_q ? ram_rdata : '0;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.vote_count = res_count_q;
	assign status.init_busy  = (state_q == BK_INIT);

	// Stage 1 terms: table lookup and the two products.
	always_comb begin
		sin_c      = sine_q14(TURN_W'(ang_q));
		cos_c      = cosine_q14(TURN_W'(ang_q));
		prod_row_c = $signed({1'b0, row_q}) * sin_c;
		prod_col_c = $signed({1'b0, col_q}) * cos_c;
	end

	// Stage 2 terms: sum and truncation toward zero.
	always_comb begin
		sum_c    = SUM_W'(prod_row_s1) + SUM_W'(prod_col_s1);
		biased_c = sum_c + (sum_c[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : SUM_W'(0));
		rho_c    = RHO_TRUNC_W'(biased_c >>> FRAC_BITS);
	end

	// Stage 3 terms: offset, range check and cell address.
	always_comb begin
		bin_c = BIN_W'(rho_s2) + BIN_W'(rho_offset_q);
		hit_c = (bin_c >= 0) && (int'(bin_c) < RHO_BINS);
	end

	// Vote pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= ang_run;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3 && hit_s3;
		end
	end

	// Vote pipeline payload.
	always_ff @(posedge clk) begin
		angle_s1    <= ang_q;
		prod_row_s1 <= prod_row_c;
		prod_col_s1 <= prod_col_c;
		angle_s2    <= angle_s1;
		rho_s2      <= rho_c;
		hit_s3      <= hit_c;
		addr_s3     <= cell_addr(angle_s2, bin_c[RHO_W-1:0]);
		addr_s4     <= addr_s3;
	end

	// Store ports: the sweep and the vote write-back never overlap.
	always_comb begin
		ram_raddr = read_go ? rd_addr_q : addr_s3;
		ram_we    = sweep || valid_s4;
		ram_waddr = sweep ? clr_q : addr_s4;
		if (sweep) begin
			ram_wdata = '0;
		end else if (ram_rdata == COUNT_MAX) begin
			ram_wdata = COUNT_MAX;
		end else begin
			ram_wdata = ram_rdata + 1'b1;
		end
	end

	hlv_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (CELL_COUNT)
	) u_vote_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// A sweep must never collide with a vote write-back.
	assert property (@(posedge clk) disable iff (!arst_n) sweep |-> !valid_s4)
		else $error("clearing sweep overlaps a vote write-back");

	// The sequencer only takes a new command with the vote pipeline empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_IDLE |-> !(valid_s1 || valid_s2 || valid_s3 || valid_s4))
		else $error("idle with votes still in flight");

	// Read-modify-write: the cell being read is never the one being written.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && hit_s3 && valid_s4 |-> addr_s3 != addr_s4)
		else $error("vote read overlaps pending write to the same cell");

	// A cell read always yields a result: the sequencer passes through BK_READ_WAIT, then sets it valid.
	assert property (@(posedge clk) disable iff (!arst_n) read_go |-> ##2 res_valid_q)
		else $error("cell read lost its result");

endmodule
